@@ src/median_filtered_boost_regulator_unit_assert.svh @@
// Assertion macros for the median filtered boost regulator.
`ifndef MEDIAN_FILTERED_BOOST_REGULATOR_UNIT_ASSERT_SVH
`define MEDIAN_FILTERED_BOOST_REGULATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define MFBR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define MFBR_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define MFBR_ASSERT(label, prop, msg)
`define MFBR_NEVER(label, cond, msg)
`endif
`endif

@@ src/mfbr_pkg.sv @@
// Package: constants, types and register map of the median filtered boost regulator.
`timescale 1ns / 1ps
package mfbr_pkg;
   localparam int WINDOW = 7;
   localparam int DATA_W = 8;
   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int MEM_AW = IDX_W + 1;
   localparam int MEM_DEPTH = 2 ** MEM_AW;
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam logic [DATA_W-1:0] RST_DUTY_MAX = 8'd46;
   localparam logic [DATA_W-1:0] RST_CURRENT_TARGET = 8'd186;
   localparam logic [DATA_W-1:0] RST_BAND_BELOW = 8'd10;
   localparam logic [DATA_W-1:0] RST_BAND_ABOVE = 8'd15;
   localparam logic [DATA_W-1:0] RST_VOLTAGE_LIMIT = 8'd254;
   localparam logic [DATA_W-1:0] RST_OVERVOLTAGE_STEP = 8'd2;

   typedef enum logic [2:0] {
      REG_DUTY_MAX         = 3'd0,
      REG_CURRENT_TARGET   = 3'd1,
      REG_BAND_BELOW       = 3'd2,
      REG_BAND_ABOVE       = 3'd3,
      REG_VOLTAGE_LIMIT    = 3'd4,
      REG_OVERVOLTAGE_STEP = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_LOAD   = 2'd1,
      ST_SORT   = 2'd2,
      ST_FINISH = 2'd3
   } state_type;

   typedef enum logic {
      CHAN_CURRENT = 1'b0,
      CHAN_VOLTAGE = 1'b1
   } chan_type;

   typedef struct packed {
      logic shift;
      logic swap;
      logic odd;
   } sort_ctl_type;
endpackage

@@ src/mfbr_median.sv @@
// Window sort register: shift-in of window samples and odd-even transposition passes.
`timescale 1ns / 1ps
module mfbr_median
   import mfbr_pkg::*;
(
   input  logic              clock,
   input  sort_ctl_type      ctl,
   input  logic [DATA_W-1:0] din,
   output logic [DATA_W-1:0] median
);
   logic [DATA_W-1:0] sort_ff [WINDOW];
   logic [DATA_W-1:0] sort_in [WINDOW];

   always_comb begin
      for (int i = 0; i < WINDOW; i++) begin
         sort_in[i] = sort_ff[i];
      end
      if (ctl.shift) begin
         for (int i = 0; i < WINDOW - 1; i++) begin
            sort_in[i] = sort_ff[i+1];
         end
         sort_in[WINDOW-1] = din;
      end else if (ctl.swap) begin
         for (int i = 0; i < WINDOW - 1; i++) begin
            if (((i % 2) == 1) == ctl.odd && sort_ff[i] > sort_ff[i+1]) begin
               sort_in[i] = sort_ff[i+1];
               sort_in[i+1] = sort_ff[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WINDOW; i++) begin
         sort_ff[i] <= sort_in[i];
      end
   end

   assign median = sort_ff[WINDOW/2];
endmodule

@@ src/median_filtered_boost_regulator_unit.sv @@
// Top level: sample windows in memory, median sequencer, duty regulation and APB registers.
`timescale 1ns / 1ps
`include "median_filtered_boost_regulator_unit_assert.svh"
// Usage:
// req_ carries one ADC item (sample, channel: 0 current, 1 voltage); it is taken at an
// edge with req_valid high and req_stall low. Each channel fills a window of WINDOW
// samples held in a window memory with one write and one read port. An item that does
// not complete its window is taken and req_stall stays low.
// The item that completes a window raises req_stall while the sequencer reads the
// window out of the memory into the sort register (ST_LOAD), runs odd-even
// compare-swap passes (ST_SORT) and takes the median (ST_FINISH).
// A completed current window updates the current level and gives no rsp_ item.
// A completed voltage window updates the duty and loads the rsp_ output register; rsp_valid
// rises at the edge that leaves ST_FINISH. The rsp_ item holds while rsp_stall is
// high; a further voltage window waits in ST_FINISH until the register is free.
// No new item is taken until the sequencer is back in ST_IDLE.
// Reset (synchronous, active high) empties both windows, clears current level and duty,
// drops rsp_valid and loads the register defaults. The csr_ APB port is always ready.
module median_filtered_boost_regulator_unit
   import mfbr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [DATA_W-1:0] req_sample,
   input  logic              req_channel,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DATA_W-1:0] rsp_duty,
   output logic [DATA_W-1:0] rsp_current_level,
   output logic [DATA_W-1:0] rsp_voltage_level,
   output logic              rsp_overvoltage,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);
   logic [DATA_W-1:0] duty_max_ff, current_target_ff, band_below_ff;
   logic [DATA_W-1:0] band_above_ff, voltage_limit_ff, overvoltage_step_ff;
   reg_index_type     csr_index;
   logic              csr_write;

   state_type         state_ff, state_in;
   chan_type          chan_ff, chan_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  cur_fill_ff, cur_fill_in, volt_fill_ff, volt_fill_in;
   logic [IDX_W-1:0]  fill_sel;
   logic              fill_full;
   logic              req_take;

   logic [DATA_W-1:0] mem [MEM_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic [MEM_AW-1:0] rd_addr;

   sort_ctl_type      sort_ctl;
   logic [DATA_W-1:0] median;

   logic [DATA_W-1:0] cur_med_ff, cur_med_in;
   logic [DATA_W-1:0] duty_ff, duty_in;
   logic              over;
   logic              hold;
   logic              rsp_load;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_duty_ff, rsp_cur_ff, rsp_volt_ff;
   logic              rsp_over_ff;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_index = reg_index_type'(csr_paddr[4:2]);
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_max_ff <= RST_DUTY_MAX;
         current_target_ff <= RST_CURRENT_TARGET;
         band_below_ff <= RST_BAND_BELOW;
         band_above_ff <= RST_BAND_ABOVE;
         voltage_limit_ff <= RST_VOLTAGE_LIMIT;
         overvoltage_step_ff <= RST_OVERVOLTAGE_STEP;
      end else if (csr_write) begin
         case (csr_index)
            REG_DUTY_MAX: begin
               duty_max_ff <= csr_pwdata[DATA_W-1:0];
            end
            REG_CURRENT_TARGET: begin
               current_target_ff <= csr_pwdata[DATA_W-1:0];
            end
            REG_BAND_BELOW: begin
               band_below_ff <= csr_pwdata[DATA_W-1:0];
            end
            REG_BAND_ABOVE: begin
               band_above_ff <= csr_pwdata[DATA_W-1:0];
            end
            REG_VOLTAGE_LIMIT: begin
               voltage_limit_ff <= csr_pwdata[DATA_W-1:0];
            end
            REG_OVERVOLTAGE_STEP: begin
               overvoltage_step_ff <= csr_pwdata[DATA_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_DUTY_MAX:         csr_prdata = CSR_DW'(duty_max_ff);
         REG_CURRENT_TARGET:   csr_prdata = CSR_DW'(current_target_ff);
         REG_BAND_BELOW:       csr_prdata = CSR_DW'(band_below_ff);
         REG_BAND_ABOVE:       csr_prdata = CSR_DW'(band_above_ff);
         REG_VOLTAGE_LIMIT:    csr_prdata = CSR_DW'(voltage_limit_ff);
         REG_OVERVOLTAGE_STEP: csr_prdata = CSR_DW'(overvoltage_step_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // Input side and window fill
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take = req_valid && !req_stall;
   assign fill_sel = req_channel ? volt_fill_ff : cur_fill_ff;
   assign fill_full = (fill_sel == IDX_W'(WINDOW - 1));

   always_ff @(posedge clock) begin
      if (req_take) begin
         mem[{req_channel, fill_sel}] <= req_sample;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_addr = {chan_ff, cnt_ff[IDX_W-1:0]};

   // Regulation step
   assign over = (median >= voltage_limit_ff);
   assign hold = (chan_ff == CHAN_VOLTAGE) && rsp_valid_ff && rsp_stall;

   always_comb begin
      duty_in = duty_ff;
      if (over) begin
         if (duty_ff >= overvoltage_step_ff) begin
            duty_in = duty_ff - overvoltage_step_ff;
         end else begin
            duty_in = '0;
         end
      end else if ((9'(cur_med_ff) + 9'(band_below_ff)) < 9'(current_target_ff)) begin
         if (duty_ff < duty_max_ff) begin
            duty_in = duty_ff + 8'd1;
         end
      end else if (9'(cur_med_ff) > (9'(current_target_ff) + 9'(band_above_ff))) begin
         if (duty_ff != '0) begin
            duty_in = duty_ff - 8'd1;
         end
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      chan_in = chan_ff;
      cnt_in = cnt_ff;
      cur_fill_in = cur_fill_ff;
      volt_fill_in = volt_fill_ff;
      cur_med_in = cur_med_ff;
      rsp_load = 1'b0;
      sort_ctl = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_channel) begin
                  volt_fill_in = fill_full ? '0 : volt_fill_ff + 1'b1;
               end else begin
                  cur_fill_in = fill_full ? '0 : cur_fill_ff + 1'b1;
               end
               if (fill_full) begin
                  state_in = ST_LOAD;
                  chan_in = chan_type'(req_channel);
                  cnt_in = '0;
               end
            end
         end
         ST_LOAD: begin
            sort_ctl.shift = (cnt_ff != '0);
            if (cnt_ff == CNT_W'(WINDOW)) begin
               state_in = ST_SORT;
               cnt_in = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SORT: begin
            sort_ctl.swap = 1'b1;
            sort_ctl.odd = cnt_ff[0];
            if (cnt_ff == CNT_W'(WINDOW - 1)) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (chan_ff == CHAN_CURRENT) begin
               cur_med_in = median;
               state_in = ST_IDLE;
            end else if (!hold) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chan_ff <= CHAN_CURRENT;
         cnt_ff <= '0;
         cur_fill_ff <= '0;
         volt_fill_ff <= '0;
         cur_med_ff <= '0;
         duty_ff <= '0;
      end else begin
         state_ff <= state_in;
         chan_ff <= chan_in;
         cnt_ff <= cnt_in;
         cur_fill_ff <= cur_fill_in;
         volt_fill_ff <= volt_fill_in;
         cur_med_ff <= cur_med_in;
         if (rsp_load) begin
            duty_ff <= duty_in;
         end
      end
   end

   mfbr_median u_median (
      .clock  (clock),
      .ctl    (sort_ctl),
      .din    (rd_data_ff),
      .median (median)
   );

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_duty_ff <= duty_in;
         rsp_cur_ff <= cur_med_ff;
         rsp_volt_ff <= median;
         rsp_over_ff <= over;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_duty = rsp_duty_ff;
   assign rsp_current_level = rsp_cur_ff;
   assign rsp_voltage_level = rsp_volt_ff;
   assign rsp_overvoltage = rsp_over_ff;

   `MFBR_ASSERT(a_full_window_loads, (req_take && fill_full) |=> (state_ff == ST_LOAD), "full window did not start readout")
   `MFBR_ASSERT(a_rsp_from_voltage, $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH && chan_ff == CHAN_VOLTAGE), "result without voltage window")
   `MFBR_ASSERT(a_finish_emits, (state_ff == ST_FINISH && chan_ff == CHAN_VOLTAGE && !hold) |=> (rsp_valid_ff && state_ff == ST_IDLE), "voltage window result lost")
   `MFBR_NEVER(a_sort_count, (state_ff == ST_SORT && cnt_ff > CNT_W'(WINDOW - 1)), "sort pass count overrun")
endmodule
